// ----- sv/u2t_pkg.sv -----
// Shared types and constants for the UTF-8 to target encoding transcoder.
// Used by u2t_front, u2t_queue, u2t_back and the top level.
package u2t_pkg;

	// Output encoding codes held in the configuration register
	localparam logic [2:0] ENC_UTF8   = 3'd0;
	localparam logic [2:0] ENC_UTF16  = 3'd1;
	localparam logic [2:0] ENC_UTF32  = 3'd2;
	localparam logic [2:0] ENC_ASCII  = 3'd3;
	localparam logic [2:0] ENC_LATIN1 = 3'd4;

	// How the back end lays out one job
	localparam logic [1:0] KIND_ONE  = 2'd0; // one byte, cp[7:0]
	localparam logic [1:0] KIND_U16  = 2'd1; // one UTF-16 unit, two bytes
	localparam logic [1:0] KIND_PAIR = 2'd2; // surrogate pair, four bytes
	localparam logic [1:0] KIND_U32  = 2'd3; // UTF-32, four bytes

	// Lead byte thresholds and payload masks
	localparam logic [7:0] LEAD4      = 8'hF0;
	localparam logic [7:0] LEAD3      = 8'hE0;
	localparam logic [7:0] LEAD2      = 8'hC0;
	localparam logic [7:0] MASK4      = 8'h07;
	localparam logic [7:0] MASK3      = 8'h0F;
	localparam logic [7:0] MASK2      = 8'h1F;
	localparam logic [20:0] PLANE1    = 21'h10000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;
	localparam logic [20:0] ASCII_LIM = 21'h80;
	localparam logic [20:0] LAT1_LIM  = 21'h100;
	localparam logic [7:0] REPL_CHAR  = 8'h3F; // '?'

	typedef struct packed {
		logic [20:0] cp;
		logic [1:0]  kind;
	} job_t;

endpackage

// ----- sv/u2t_front.sv -----
// Front end: accepts input words, runs the lax UTF-8 decoder and classifies
// each finished code point (each input byte in passthrough) into a job. Depends on u2t_pkg.
module u2t_front import u2t_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_fire,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       job_push,
	output job_t       job
);

	logic [2:0]  mode_q;
	logic [20:0] acc_q;
	logic [1:0]  be_q;
	logic [20:0] acc_n;
	logic [1:0]  be_n;
	logic [20:0] cp;
	logic        done;

	// Hold the output encoding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ENC_UTF8;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Decode one byte: lead classification or continuation shift
	always_comb begin
		acc_n = acc_q;
		be_n  = be_q;
		cp    = '0;
		done  = 1'b0;
		if (be_q == 2'd0) begin
			priority if (in_byte >= LEAD4) begin
				acc_n = {13'd0, in_byte & MASK4};
				be_n  = 2'd3;
			end else if (in_byte >= LEAD3) begin
				acc_n = {13'd0, in_byte & MASK3};
				be_n  = 2'd2;
			end else if (in_byte >= LEAD2) begin
				acc_n = {13'd0, in_byte & MASK2};
				be_n  = 2'd1;
			end else begin
				cp   = {13'd0, in_byte};
				done = 1'b1;
			end
		end else begin
			acc_n = {acc_q[14:0], in_byte[5:0]};
			be_n  = be_q - 2'd1;
			if (be_n == 2'd0) begin
				cp   = acc_n;
				done = 1'b1;
			end
		end
		// flush a truncated sequence at end of text
		if (!done && end_of_text && be_n != 2'd0) begin
			cp   = acc_n;
			done = 1'b1;
		end
	end

	// Advance decoder state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			be_q  <= '0;
		end else if (in_fire) begin
			if (end_of_text || done) begin
				acc_q <= '0;
				be_q  <= '0;
			end else begin
				acc_q <= acc_n;
				be_q  <= be_n;
			end
		end
	end

	// Classify the job for the back end
	always_comb begin
		job.cp   = cp;
		job.kind = KIND_ONE;
		unique case (mode_q)
			ENC_UTF8: begin
				job.cp = {13'd0, in_byte};
			end
			ENC_UTF16: begin
				job.kind = (cp >= PLANE1) ? KIND_PAIR : KIND_U16;
			end
			ENC_UTF32: begin
				job.kind = KIND_U32;
			end
			ENC_ASCII: begin
				if (cp >= ASCII_LIM) job.cp = {13'd0, REPL_CHAR};
			end
			default: begin
				if (cp >= LAT1_LIM) job.cp = {13'd0, REPL_CHAR};
			end
		endcase
	end

	assign job_push = in_fire && (mode_q == ENC_UTF8 || done);

	// End of text always leaves the decoder empty
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_text |=> be_q == 2'd0 && acc_q == '0)
		else $error("decoder state not cleared after end of text");

	// A pending sequence never produces a job outside passthrough
	a_pending_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !end_of_text && mode_q != ENC_UTF8 && be_n != 2'd0
		|-> !job_push)
		else $error("job emitted while a sequence is pending");

endmodule

// ----- sv/u2t_queue.sv -----
// Short job queue between the decoder front end and the byte serialiser.
// Depends on u2t_pkg for the job type.
module u2t_queue import u2t_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full job queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty job queue");

endmodule

// ----- sv/u2t_back.sv -----
// Back end: takes jobs from the queue, lays out the encoded bytes and sends
// one output word per cycle while out_ready is high. Depends on u2t_pkg.
module u2t_back import u2t_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run
);

	logic        busy_q;
	logic [31:0] word_q;
	logic [1:0]  idx_q;
	logic [1:0]  last_q;
	logic [31:0] word_n;
	logic [1:0]  last_n;
	logic [20:0] off;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic        fire;
	logic        at_last;

	assign fire    = out_valid && out_ready;
	assign at_last = (idx_q == last_q);
	assign q_pop   = !q_empty && (!busy_q || (fire && at_last));

	// Lay out the bytes of the incoming job
	always_comb begin
		off     = q_job.cp - PLANE1;
		hi_unit = HI_SURR | {5'd0, off[20:10]};
		lo_unit = LO_SURR | {6'd0, off[9:0]};
		unique case (q_job.kind)
			KIND_ONE: begin
				word_n = {24'd0, q_job.cp[7:0]};
				last_n = 2'd0;
			end
			KIND_U16: begin
				word_n = {16'd0, q_job.cp[15:0]};
				last_n = 2'd1;
			end
			KIND_PAIR: begin
				word_n = {lo_unit, hi_unit};
				last_n = 2'd3;
			end
			default: begin
				word_n = {11'd0, q_job.cp};
				last_n = 2'd3;
			end
		endcase
	end

	// Load a job or step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			last_q <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			last_q <= last_n;
		end else if (fire) begin
			if (at_last) busy_q <= 1'b0;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) word_q <= word_n;
	end

	assign out_valid   = busy_q;
	assign out_byte    = word_q[{idx_q, 3'b000} +: 8];
	assign last_of_run = at_last;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_q)
		else $error("byte index past end of job");

	a_hold_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !fire |=> busy_q && $stable(idx_q) && $stable(word_q))
		else $error("stalled output word changed");

endmodule

// ----- sv/utf8_to_target_encoder.sv -----
// Top level of the UTF-8 to target encoding transcoder.
// Instantiates u2t_front, u2t_queue and u2t_back; depends on u2t_pkg.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tdata[7:0] in_byte, s_tlast end_of_text
//  m_*      | out       | m_tvalid/m_tready  | m_tdata[7:0] out_byte, m_tlast last_of_run
//  cfg_*    | in        | cfg_wr_en          | cfg_wr_data[2:0] output_encoding
//
// The front end decodes one input word per cycle while the job queue has room.
// The back end sends one output word per cycle while m_tready is high:
// one word for passthrough, ASCII and Latin-1, two for a UTF-16 unit,
// four for a surrogate pair or UTF-32, so the sustained input rate is set
// by the bytes each character expands to.
// Reset clears decoder state, queue pointers and the encoding register (UTF-8).
// An output stall fills the QUEUE_DEPTH-entry job queue, then drops s_tready.
module utf8_to_target_encoder import u2t_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] in_byte
	input  logic       s_tlast,    // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tlast     // last_of_run
);

	logic in_fire;
	logic job_push;
	job_t job;
	logic q_pop;
	job_t q_job;
	logic q_full;
	logic q_empty;

	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	// Decode and classify
	u2t_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_fire     (in_fire),
		.in_byte     (s_tdata),
		.end_of_text (s_tlast),
		.job_push    (job_push),
		.job         (job)
	);

	// Decouple front and back
	u2t_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.pop      (q_pop),
		.pop_job  (q_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Serialise encoded bytes
	u2t_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (q_job),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_byte    (m_tdata),
		.last_of_run (m_tlast)
	);

endmodule
